// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/flba_pkg.sv =====
`default_nettype none

package flba_pkg;

    // fixed field widths
    localparam int IDX_W    = 10;
    localparam int STATUS_W = 2;
    localparam int POOL_W   = 11;

    // pool size after reset
    localparam logic [POOL_W-1:0] POOL_SIZE_RESET = 11'd1024;

    // request operations
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // response status codes
    localparam logic [STATUS_W-1:0] STATUS_GRANT = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FREED = 2'd2;

    // one response item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    granted_index;
    } result_t;

    // controller to datapath commands
    typedef struct packed {
        logic sweep;
        logic accept;
        logic exec;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic sweep_last;
        logic buf_full;
    } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/flba_req_if.sv =====
`default_nettype none

interface flba_req_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [flba_pkg::IDX_W-1:0]  block_index;

    modport source (output valid, output operation, output block_index, input ready);
    modport sink   (input valid, input operation, input block_index, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/flba_rsp_if.sv =====
`default_nettype none

interface flba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [flba_pkg::STATUS_W-1:0] status;
    logic [flba_pkg::IDX_W-1:0]    granted_index;

    modport source (output valid, output status, output granted_index, input ready);
    modport sink   (input valid, input status, input granted_index, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/flba_ram.sv =====
`default_nettype none

module flba_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/flba_ctl.sv =====
`default_nettype none

module flba_ctl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic            in_valid,
    input  wire flba_pkg::sts_t  sts,
    output flba_pkg::cmd_t       cmd,
    output logic                 in_ready
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    // request side is open only when idle, not being reconfigured, and the
    // response buffer has room
    assign in_ready = (state_reg == ST_IDLE) && !cfg_we && !sts.buf_full;

    // commands to the datapath
    always_comb
    begin
        cmd        = '0;
        cmd.sweep  = (state_reg == ST_CLEAR) && !cfg_we;
        cmd.accept = in_ready && in_valid;
        cmd.exec   = (state_reg == ST_EXEC);
    end

    // next state, a pool size write always restarts the list rebuild
    always_comb
    begin
        state_next = state_reg;
        if (cfg_we)
        begin
            state_next = ST_CLEAR;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (sts.sweep_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (cmd.accept)
                    begin
                        state_next = ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    state_next = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_CLEAR;
                end
            endcase
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/flba_dp.sv =====
`default_nettype none

module flba_dp #(
    parameter int NUM_BLOCKS = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire flba_pkg::cmd_t                cmd,
    output flba_pkg::sts_t                     sts,
    input  wire logic                          cfg_we,
    input  wire logic [flba_pkg::POOL_W-1:0]   cfg_wdata,
    input  wire logic                          in_op,
    input  wire logic [flba_pkg::IDX_W-1:0]    in_idx,
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output flba_pkg::result_t                  rsp_data
);

    // address, link and compare widths
    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int LW = $clog2(NUM_BLOCKS + 1);
    localparam int CW = (LW > flba_pkg::POOL_W) ? LW : flba_pkg::POOL_W;

    localparam logic [LW-1:0] NULL_LINK = LW'(NUM_BLOCKS);
    localparam logic [CW-1:0] POOL_MAX  = CW'(NUM_BLOCKS);
    localparam logic [AW-1:0] SWEEP_END = AW'(NUM_BLOCKS - 1);

    logic [flba_pkg::POOL_W-1:0] pool_size_reg;
    logic [LW-1:0]               head_reg;
    logic [LW-1:0]               head_next;
    logic [AW-1:0]               sweep_cnt_reg;
    logic [AW-1:0]               sweep_cnt_next;
    logic                        op_reg;
    logic [flba_pkg::IDX_W-1:0]  idx_reg;
    flba_pkg::result_t           slot0_reg;
    flba_pkg::result_t           slot1_reg;
    logic [1:0]                  count_reg;

    logic [CW-1:0]     psz_w;
    logic [CW-1:0]     n_w;
    logic [CW-1:0]     head_w;
    logic [CW-1:0]     idx_w;
    logic [CW-1:0]     sweep_succ;
    logic [LW-1:0]     sweep_link;
    logic              head_null;
    logic              in_range;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [LW-1:0]     ram_wdata;
    logic [LW-1:0]     ram_rdata;
    flba_pkg::result_t result;
    logic              push;
    logic              pop;

    // blocks in use: zero acts as one, clamped to the pool depth
    assign psz_w = CW'(pool_size_reg);
    always_comb
    begin
        if (psz_w == '0)
        begin
            n_w = CW'(1);
        end
        else if (psz_w > POOL_MAX)
        begin
            n_w = POOL_MAX;
        end
        else
        begin
            n_w = psz_w;
        end
    end

    assign head_w    = CW'(head_reg);
    assign idx_w     = CW'(idx_reg);
    assign head_null = (head_reg >= NULL_LINK);
    assign in_range  = (idx_w < n_w);

    // rebuild chain entry for the sweep
    assign sweep_succ = CW'(sweep_cnt_reg) + CW'(1);
    assign sweep_link = (sweep_succ < n_w) ? LW'(sweep_succ) : NULL_LINK;

    // link memory port muxing
    assign ram_we    = cmd.sweep || (cmd.exec && (op_reg == flba_pkg::OP_FREE) && in_range);
    assign ram_waddr = cmd.sweep ? sweep_cnt_reg : AW'(idx_w);
    assign ram_wdata = cmd.sweep ? sweep_link : head_reg;

    flba_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.accept),
        .raddr (AW'(head_reg)),
        .rdata (ram_rdata)
    );

    // pop or push of the list head, and the response
    always_comb
    begin
        head_next            = head_reg;
        result.status        = flba_pkg::STATUS_FREED;
        result.granted_index = '0;
        case (op_reg)
            flba_pkg::OP_ALLOC:
            begin
                if (head_null)
                begin
                    result.status = flba_pkg::STATUS_EMPTY;
                end
                else
                begin
                    result.status        = flba_pkg::STATUS_GRANT;
                    result.granted_index = head_w[flba_pkg::IDX_W-1:0];
                    head_next            = ram_rdata;
                end
            end
            default:
            begin
                if (in_range)
                begin
                    head_next = LW'(idx_w);
                end
            end
        endcase
    end

    // sweep counter
    always_comb
    begin
        sweep_cnt_next = sweep_cnt_reg;
        if (cfg_we)
        begin
            sweep_cnt_next = '0;
        end
        else if (cmd.sweep)
        begin
            sweep_cnt_next = sweep_cnt_reg + AW'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg <= flba_pkg::POOL_SIZE_RESET;
            head_reg      <= '0;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            sweep_cnt_reg <= sweep_cnt_next;
            if (cfg_we)
            begin
                pool_size_reg <= cfg_wdata;
                head_reg      <= '0;
            end
            else if (cmd.exec)
            begin
                head_reg <= head_next;
            end
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= in_op;
            idx_reg <= in_idx;
        end
    end

    // two-entry response buffer
    assign push      = cmd.exec;
    assign pop       = rsp_valid && rsp_ready;
    assign rsp_valid = (count_reg != 2'd0);
    assign rsp_data  = slot0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (push && !pop)
        begin
            count_reg <= count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !pop)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_reg <= result;
            end
            else
            begin
                slot1_reg <= result;
            end
        end
        else if (pop && !push)
        begin
            slot0_reg <= slot1_reg;
        end
        else if (push && pop)
        begin
            if (count_reg == 2'd1)
            begin
                slot0_reg <= result;
            end
            else
            begin
                slot0_reg <= slot1_reg;
                slot1_reg <= result;
            end
        end
    end

    // status to the controller
    always_comb
    begin
        sts            = '0;
        sts.sweep_last = (sweep_cnt_reg == SWEEP_END);
        sts.buf_full   = (count_reg == 2'd2);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/free_list_block_allocator_top.sv =====
// free-list block allocator
// req channel: operation (allocate or free) and block_index, one transfer
// per request; rsp channel: status and granted_index, one transfer per
// request, in request order.
// cfg_we with cfg_wdata writes the pool size and rebuilds the free list.
// an allocate pops the list head; a free pushes block_index as new head
// (a free outside the pool leaves the list alone but is still answered).
// in the core, the accept cycle of a request reads the link memory at the
// head and the next cycle updates head and link; no new request is taken
// until that update is done. its response is registered into the response
// buffer in the update cycle and offered from the cycle after it.
// after reset, and after every pool size write, a rebuild pass writes the
// link memory one entry a cycle (a pool size write restarts it), all NUM_BLOCKS entries, with req.ready low.
// responses wait in a two-entry buffer; a stalled rsp lets one more request
// in, after that req.ready stays low until rsp transfers resume.
`default_nettype none

`include "assert_macros.svh"

module free_list_block_allocator_top #(
    parameter int NUM_BLOCKS = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    flba_req_if.sink                         req,
    flba_rsp_if.source                       rsp,
    input  wire logic                        cfg_we,
    input  wire logic [flba_pkg::POOL_W-1:0] cfg_wdata
);

    flba_pkg::cmd_t    cmd;
    flba_pkg::sts_t    sts;
    flba_pkg::result_t rsp_data;
    logic              in_ready;
    logic              rsp_valid;

    // sequencer
    flba_ctl u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .in_valid (req.valid),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    // head register, link memory and response buffer
    flba_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_op     (req.operation),
        .in_idx    (req.block_index),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp_data)
    );

    // channel hookup
    assign req.ready         = in_ready;
    assign rsp.valid         = rsp_valid;
    assign rsp.status        = rsp_data.status;
    assign rsp.granted_index = rsp_data.granted_index;

    // checks
    `ASSERT_NEXT(a_busy_after_req, clk, rst_n, req.valid && req.ready, !req.ready, "request taken while previous one in flight")
    `ASSERT_NEXT(a_rebuild_after_cfg, clk, rst_n, cfg_we, !req.ready, "request taken during list rebuild")
    `ASSERT_IMPLY(a_no_index_unless_grant, clk, rst_n, rsp.valid && (rsp.status != flba_pkg::STATUS_GRANT), rsp.granted_index == '0, "index given without a grant")

endmodule

`default_nettype wire
